/* rtl/core/alds_pkg.sv */
// ----------------------------------------------------------------------------
// alds_pkg
// Shared widths, latencies, cell words and the arctangent table of the
// steering core.
// ----------------------------------------------------------------------------
package alds_pkg;

	localparam int COMP_W      = 16;
	localparam int FRAC_BITS   = 14;
	localparam int OUT_W       = FRAC_BITS + 2;
	localparam int ONE         = 1 << FRAC_BITS;
	localparam int HALF        = 1 << (FRAC_BITS - 1);
	localparam int ONE_SQ      = 1 << (2 * FRAC_BITS);

	localparam int NORM_W      = 18;
	localparam int MAG_W       = 17;
	localparam int SQ_W        = 36;
	localparam int SQ_RES_W    = 18;
	localparam int SQ_T_W      = 38;
	localparam int SQ_STEP_W   = 5;

	localparam int DIV_W       = 36;
	localparam int DIV_D_W     = 18;
	localparam int DIV_T_W     = 37;
	localparam int QUO_W       = 15;
	localparam int DIV_STEP_W  = 4;

	localparam int CORDIC_STEPS = 14;
	localparam int CD_STEP_W   = 4;
	localparam int CX_W        = 20;
	localparam int ANG_W       = 17;
	localparam int ANG_PI      = 25736;
	localparam int ANG_HALF_PI = 12868;

	localparam int CFG_W       = 11;
	localparam int CFG_RESET   = 450;
	localparam int TENTHS_HALF = 900;
	localparam int TN_W        = 26;
	localparam int ND_W        = 23;
	localparam int RECIP_W     = 24;
	localparam int RECIP_225   = 9544372;
	localparam int RECIP_SHIFT = 31;
	localparam int RP_W        = ND_W + RECIP_W;
	localparam int LIM_W       = 15;

	localparam int DSUM_W      = 2 * OUT_W + 2;
	localparam int BP_W        = 2 * OUT_W + 2;

	localparam int NORM_LAT    = 1 + SQ_RES_W + 1 + QUO_W + 1;
	localparam int MID_LAT     = 3 + SQ_RES_W + 1 + CORDIC_STEPS + 1 + QUO_W;
	localparam int LIM_LAT     = QUO_W + 2 + NORM_LAT;
	localparam int V2_LAT      = MID_LAT + 2 + NORM_LAT;
	localparam int PIPE_LAT    = NORM_LAT + MID_LAT + 2 + NORM_LAT + 1;

	typedef struct packed {
		logic [SQ_W-1:0]     rem;
		logic [SQ_RES_W-1:0] root;
	} sqrt_word_t;

	typedef struct packed {
		logic [DIV_W-1:0]   rem;
		logic [DIV_D_W-1:0] den;
		logic [QUO_W-1:0]   quo;
	} div_word_t;

	typedef struct packed {
		logic signed [CX_W-1:0]  x;
		logic signed [CX_W-1:0]  y;
		logic signed [ANG_W-1:0] z;
	} cordic_word_t;

	// arctan(2^-i) in Q3.13 radians
	function automatic logic signed [ANG_W-1:0] atan_q13(input logic [CD_STEP_W-1:0] i);
		logic signed [ANG_W-1:0] r;
		case (i)
			4'd0:    r = ANG_W'(6434);
			4'd1:    r = ANG_W'(3798);
			4'd2:    r = ANG_W'(2007);
			4'd3:    r = ANG_W'(1019);
			4'd4:    r = ANG_W'(511);
			4'd5:    r = ANG_W'(256);
			4'd6:    r = ANG_W'(128);
			4'd7:    r = ANG_W'(64);
			4'd8:    r = ANG_W'(32);
			4'd9:    r = ANG_W'(16);
			4'd10:   r = ANG_W'(8);
			4'd11:   r = ANG_W'(4);
			4'd12:   r = ANG_W'(2);
			4'd13:   r = ANG_W'(1);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

/* rtl/core/alds_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// alds_sqrt_cell
// One root bit of a restoring integer square root; registered word out.
// ----------------------------------------------------------------------------
module alds_sqrt_cell import alds_pkg::*; (
	input  logic                 clk,
	input  logic [SQ_STEP_W-1:0] step,
	input  sqrt_word_t           d_in,
	output sqrt_word_t           d_out
);

	logic [SQ_T_W-1:0] trial;
	logic [SQ_T_W-1:0] rem_x;
	logic              take;
	sqrt_word_t        word_s1;

	always_comb begin
		trial = (SQ_T_W'(d_in.root) << ({1'b0, step} + 6'd1)) + (SQ_T_W'(1) << {step, 1'b0});
		rem_x = SQ_T_W'(d_in.rem);
		take  = (rem_x >= trial);
	end

	always_ff @(posedge clk) begin
		if (take) begin
			word_s1.rem  <= SQ_W'(rem_x - trial);
			word_s1.root <= d_in.root | (SQ_RES_W'(1) << step);
		end else begin
			word_s1 <= d_in;
		end
	end

	assign d_out = word_s1;

endmodule

/* rtl/core/alds_div_cell.sv */
// ----------------------------------------------------------------------------
// alds_div_cell
// One quotient bit of a restoring divider; registered word out.
// ----------------------------------------------------------------------------
module alds_div_cell import alds_pkg::*; (
	input  logic                  clk,
	input  logic [DIV_STEP_W-1:0] step,
	input  div_word_t             d_in,
	output div_word_t             d_out
);

	logic [DIV_T_W-1:0] trial;
	logic [DIV_T_W-1:0] rem_x;
	logic               take;
	div_word_t          word_s1;

	always_comb begin
		trial = DIV_T_W'(d_in.den) << step;
		rem_x = DIV_T_W'(d_in.rem);
		take  = (rem_x >= trial);
	end

	always_ff @(posedge clk) begin
		word_s1.den <= d_in.den;
		if (take) begin
			word_s1.rem <= DIV_W'(rem_x - trial);
			word_s1.quo <= d_in.quo | (QUO_W'(1) << step);
		end else begin
			word_s1.rem <= d_in.rem;
			word_s1.quo <= d_in.quo;
		end
	end

	assign d_out = word_s1;

endmodule

/* rtl/core/alds_cordic_cell.sv */
// ----------------------------------------------------------------------------
// alds_cordic_cell
// One vectoring CORDIC rotation; registered word out.
// ----------------------------------------------------------------------------
module alds_cordic_cell import alds_pkg::*; (
	input  logic                 clk,
	input  logic [CD_STEP_W-1:0] step,
	input  cordic_word_t         d_in,
	output cordic_word_t         d_out
);

	logic signed [CX_W-1:0] dx;
	logic signed [CX_W-1:0] dy;
	cordic_word_t           word_s1;

	always_comb begin
		dx = d_in.y >>> step;
		dy = d_in.x >>> step;
	end

	always_ff @(posedge clk) begin
		if (d_in.y > 0) begin
			word_s1.x <= d_in.x + dx;
			word_s1.y <= d_in.y - dy;
			word_s1.z <= d_in.z + atan_q13(step);
		end else begin
			word_s1.x <= d_in.x - dx;
			word_s1.y <= d_in.y + dy;
			word_s1.z <= d_in.z - atan_q13(step);
		end
	end

	assign d_out = word_s1;

endmodule

/* rtl/core/alds_norm.sv */
// ----------------------------------------------------------------------------
// alds_norm
// Vector normaliser: sum of squares, square-root cell row, then a row of
// divider cells per component. Zero vector gives zero.
// ----------------------------------------------------------------------------
module alds_norm import alds_pkg::*; (
	input  logic                     clk,
	input  logic signed [NORM_W-1:0] comp_x,
	input  logic signed [NORM_W-1:0] comp_y,
	input  logic signed [NORM_W-1:0] comp_z,
	output logic signed [OUT_W-1:0]  unit_x,
	output logic signed [OUT_W-1:0]  unit_y,
	output logic signed [OUT_W-1:0]  unit_z
);

	logic signed [NORM_W-1:0] comp   [3];
	logic [NORM_W-1:0]        abs_c  [3];
	logic [2*MAG_W-1:0]       sq_c   [3];
	logic [MAG_W-1:0]         mag_s1 [3];
	logic                     neg_s1 [3];
	logic [SQ_W-1:0]          sum_s1;
	logic [MAG_W-1:0]         mag_q  [SQ_RES_W][3];
	logic                     neg_q  [SQ_RES_W][3];
	sqrt_word_t               sq_w   [SQ_RES_W+1];
	logic [SQ_RES_W-1:0]      len;
	div_word_t                dv_s2  [3];
	logic                     neg_s2 [3];
	logic                     zero_s2;
	div_word_t                dv_w   [3][QUO_W+1];
	logic                     negd_q [QUO_W][3];
	logic                     zero_q [QUO_W];
	logic signed [OUT_W-1:0]  unit_s3 [3];

	assign comp[0] = comp_x;
	assign comp[1] = comp_y;
	assign comp[2] = comp_z;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			abs_c[i] = comp[i][NORM_W-1] ? NORM_W'(-comp[i]) : NORM_W'(comp[i]);
			sq_c[i]  = abs_c[i][MAG_W-1:0] * abs_c[i][MAG_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			mag_s1[i] <= abs_c[i][MAG_W-1:0];
			neg_s1[i] <= comp[i][NORM_W-1];
		end
		sum_s1 <= SQ_W'(sq_c[0]) + SQ_W'(sq_c[1]) + SQ_W'(sq_c[2]);
	end

	assign sq_w[0] = '{rem: sum_s1, root: '0};

	for (genvar g = 0; g < SQ_RES_W; g++) begin : g_sqrt
		alds_sqrt_cell u_cell (
			.clk   (clk),
			.step  (SQ_STEP_W'(SQ_RES_W - 1 - g)),
			.d_in  (sq_w[g]),
			.d_out (sq_w[g+1])
		);
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			mag_q[0][i] <= mag_s1[i];
			neg_q[0][i] <= neg_s1[i];
			for (int j = 1; j < SQ_RES_W; j++) begin
				mag_q[j][i] <= mag_q[j-1][i];
				neg_q[j][i] <= neg_q[j-1][i];
			end
		end
	end

	assign len = sq_w[SQ_RES_W].root;

	// rounded quotient: (mag * one + len/2) / len
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			dv_s2[i].rem <= DIV_W'({mag_q[SQ_RES_W-1][i], {FRAC_BITS{1'b0}}})
				+ DIV_W'(len >> 1);
			dv_s2[i].den <= len;
			dv_s2[i].quo <= '0;
			neg_s2[i]    <= neg_q[SQ_RES_W-1][i];
		end
		zero_s2 <= (len == '0);
	end

	for (genvar l = 0; l < 3; l++) begin : g_lane
		assign dv_w[l][0] = dv_s2[l];
		for (genvar g = 0; g < QUO_W; g++) begin : g_div
			alds_div_cell u_cell (
				.clk   (clk),
				.step  (DIV_STEP_W'(QUO_W - 1 - g)),
				.d_in  (dv_w[l][g]),
				.d_out (dv_w[l][g+1])
			);
		end
	end

	always_ff @(posedge clk) begin
		zero_q[0] <= zero_s2;
		for (int j = 1; j < QUO_W; j++) begin
			zero_q[j] <= zero_q[j-1];
		end
		for (int i = 0; i < 3; i++) begin
			negd_q[0][i] <= neg_s2[i];
			for (int j = 1; j < QUO_W; j++) begin
				negd_q[j][i] <= negd_q[j-1][i];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (zero_q[QUO_W-1]) begin
				unit_s3[i] <= '0;
			end else if (negd_q[QUO_W-1][i]) begin
				unit_s3[i] <= OUT_W'(0) - OUT_W'(dv_w[i][QUO_W].quo);
			end else begin
				unit_s3[i] <= OUT_W'(dv_w[i][QUO_W].quo);
			end
		end
	end

	assign unit_x = unit_s3[0];
	assign unit_y = unit_s3[1];
	assign unit_z = unit_s3[2];

endmodule

/* rtl/core/angle_limited_direction_steer_core.sv */
// ----------------------------------------------------------------------------
// angle_limited_direction_steer_core
// The path from start to done runs through the cell rows of the
// two normalisers, the dot-product square root, CORDIC and blend divider.
// Throughput: one word per cycle; busy stays low, done strobes once per word.
// Reset clears the valid line and loads the turn limit with 45.0 degrees.
// ----------------------------------------------------------------------------
module angle_limited_direction_steer_core import alds_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic signed [COMP_W-1:0] cur_x,
	input  logic signed [COMP_W-1:0] cur_y,
	input  logic signed [COMP_W-1:0] cur_z,
	input  logic signed [COMP_W-1:0] want_x,
	input  logic signed [COMP_W-1:0] want_y,
	input  logic signed [COMP_W-1:0] want_z,
	input  logic                     cfg_we,
	input  logic [CFG_W-1:0]         cfg_wdata,
	output logic                     done,
	output logic signed [OUT_W-1:0]  out_x,
	output logic signed [OUT_W-1:0]  out_y,
	output logic signed [OUT_W-1:0]  out_z,
	output logic                     was_limited
);

	logic [CFG_W-1:0]          cfg_q;
	logic [ND_W-1:0]           nd_q;
	logic [RP_W-1:0]           rp_c;
	logic [LIM_W-1:0]          limit_q;
	logic [PIPE_LAT-1:0]       vld_q;

	logic signed [OUT_W-1:0]   v1 [3];
	logic signed [OUT_W-1:0]   v2 [3];
	logic signed [2*OUT_W-1:0] prod_s1 [3];
	logic signed [DSUM_W-1:0]  dsum_c;
	logic signed [DSUM_W-1:0]  dround_c;
	logic signed [OUT_W-1:0]   dot_s2;
	logic [2*OUT_W-1:0]        dsq_s3;
	logic signed [OUT_W-1:0]   dot_s3;
	logic signed [OUT_W-1:0]   dot_q [SQ_RES_W];
	sqrt_word_t                ac_w [SQ_RES_W+1];
	cordic_word_t              cw_s4;
	cordic_word_t              cd_w [CORDIC_STEPS+1];
	logic signed [ANG_W-1:0]   angle;
	logic                      lim_s5;
	div_word_t                 dv_s5;
	div_word_t                 dq_w [QUO_W+1];
	logic [QUO_W-1:0]          frac;
	logic signed [OUT_W-1:0]   v1_q [MID_LAT][3];
	logic signed [OUT_W-1:0]   v2_q [V2_LAT][3];
	logic signed [OUT_W:0]     diff_c [3];
	logic signed [BP_W-1:0]    bp_s6 [3];
	logic signed [OUT_W-1:0]   v1_s6 [3];
	logic signed [NORM_W-1:0]  bl_s7 [3];
	logic signed [OUT_W-1:0]   rn [3];
	logic                      lim_q [LIM_LAT];
	logic signed [OUT_W-1:0]   res_q [3];
	logic                      lim_out_q;

	assign busy = 1'b0;

	// turn limit register and its conversion to Q3.13 radians
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_W'(CFG_RESET);
		end else if (cfg_we) begin
			cfg_q <= cfg_wdata;
		end
	end

	assign rp_c = RP_W'(nd_q) * RP_W'(RECIP_225);

	always_ff @(posedge clk) begin
		nd_q    <= ND_W'((TN_W'(cfg_q) * TN_W'(ANG_PI) + TN_W'(TENTHS_HALF)) >> 3);
		limit_q <= LIM_W'(rp_c >> RECIP_SHIFT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[PIPE_LAT-2:0], start & ~busy};
		end
	end

	assign done = vld_q[PIPE_LAT-1];

	alds_norm u_norm_cur (
		.clk    (clk),
		.comp_x ({{(NORM_W-COMP_W){cur_x[COMP_W-1]}}, cur_x}),
		.comp_y ({{(NORM_W-COMP_W){cur_y[COMP_W-1]}}, cur_y}),
		.comp_z ({{(NORM_W-COMP_W){cur_z[COMP_W-1]}}, cur_z}),
		.unit_x (v1[0]),
		.unit_y (v1[1]),
		.unit_z (v1[2])
	);

	alds_norm u_norm_want (
		.clk    (clk),
		.comp_x ({{(NORM_W-COMP_W){want_x[COMP_W-1]}}, want_x}),
		.comp_y ({{(NORM_W-COMP_W){want_y[COMP_W-1]}}, want_y}),
		.comp_z ({{(NORM_W-COMP_W){want_z[COMP_W-1]}}, want_z}),
		.unit_x (v2[0]),
		.unit_y (v2[1]),
		.unit_z (v2[2])
	);

	// dot product, rounded and clamped
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			prod_s1[i] <= (2*OUT_W)'(v1[i]) * (2*OUT_W)'(v2[i]);
		end
	end

	always_comb begin
		dsum_c   = DSUM_W'(prod_s1[0]) + DSUM_W'(prod_s1[1]) + DSUM_W'(prod_s1[2]);
		dround_c = (dsum_c + DSUM_W'(HALF)) >>> FRAC_BITS;
	end

	always_ff @(posedge clk) begin
		if (dround_c > DSUM_W'(ONE)) begin
			dot_s2 <= OUT_W'(ONE);
		end else if (dround_c < -DSUM_W'(ONE)) begin
			dot_s2 <= -OUT_W'(ONE);
		end else begin
			dot_s2 <= OUT_W'(dround_c);
		end
	end

	always_ff @(posedge clk) begin
		dsq_s3 <= (2*OUT_W)'((2*OUT_W)'(dot_s2) * (2*OUT_W)'(dot_s2));
		dot_s3 <= dot_s2;
	end

	// s = sqrt(one^2 - dot^2)
	assign ac_w[0] = '{rem: SQ_W'(ONE_SQ) - SQ_W'(dsq_s3), root: '0};

	for (genvar g = 0; g < SQ_RES_W; g++) begin : g_sqrt
		alds_sqrt_cell u_cell (
			.clk   (clk),
			.step  (SQ_STEP_W'(SQ_RES_W - 1 - g)),
			.d_in  (ac_w[g]),
			.d_out (ac_w[g+1])
		);
	end

	always_ff @(posedge clk) begin
		dot_q[0] <= dot_s3;
		for (int j = 1; j < SQ_RES_W; j++) begin
			dot_q[j] <= dot_q[j-1];
		end
	end

	always_ff @(posedge clk) begin
		if (dot_q[SQ_RES_W-1] < 0) begin
			cw_s4.x <= CX_W'(ac_w[SQ_RES_W].root);
			cw_s4.y <= -CX_W'(dot_q[SQ_RES_W-1]);
			cw_s4.z <= ANG_W'(ANG_HALF_PI);
		end else begin
			cw_s4.x <= CX_W'(dot_q[SQ_RES_W-1]);
			cw_s4.y <= CX_W'(ac_w[SQ_RES_W].root);
			cw_s4.z <= '0;
		end
	end

	assign cd_w[0] = cw_s4;

	for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
		alds_cordic_cell u_cell (
			.clk   (clk),
			.step  (CD_STEP_W'(g)),
			.d_in  (cd_w[g]),
			.d_out (cd_w[g+1])
		);
	end

	assign angle = cd_w[CORDIC_STEPS].z;

	// blend fraction = limit * one / angle
	always_ff @(posedge clk) begin
		lim_s5    <= (angle > $signed(ANG_W'(limit_q)));
		dv_s5.rem <= DIV_W'({limit_q, {FRAC_BITS{1'b0}}});
		dv_s5.den <= DIV_D_W'($unsigned(angle));
		dv_s5.quo <= '0;
	end

	assign dq_w[0] = dv_s5;

	for (genvar g = 0; g < QUO_W; g++) begin : g_div
		alds_div_cell u_cell (
			.clk   (clk),
			.step  (DIV_STEP_W'(QUO_W - 1 - g)),
			.d_in  (dq_w[g]),
			.d_out (dq_w[g+1])
		);
	end

	assign frac = dq_w[QUO_W].quo;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			v1_q[0][i] <= v1[i];
			v2_q[0][i] <= v2[i];
			for (int j = 1; j < MID_LAT; j++) begin
				v1_q[j][i] <= v1_q[j-1][i];
			end
			for (int j = 1; j < V2_LAT; j++) begin
				v2_q[j][i] <= v2_q[j-1][i];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			diff_c[i] = (OUT_W+1)'(v2_q[MID_LAT-1][i]) - (OUT_W+1)'(v1_q[MID_LAT-1][i]);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			bp_s6[i] <= BP_W'(diff_c[i]) * BP_W'($signed({1'b0, frac}));
			v1_s6[i] <= v1_q[MID_LAT-1][i];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			bl_s7[i] <= NORM_W'(BP_W'(v1_s6[i]) + ((bp_s6[i] + BP_W'(HALF)) >>> FRAC_BITS));
		end
	end

	alds_norm u_norm_blend (
		.clk    (clk),
		.comp_x (bl_s7[0]),
		.comp_y (bl_s7[1]),
		.comp_z (bl_s7[2]),
		.unit_x (rn[0]),
		.unit_y (rn[1]),
		.unit_z (rn[2])
	);

	always_ff @(posedge clk) begin
		lim_q[0] <= lim_s5;
		for (int j = 1; j < LIM_LAT; j++) begin
			lim_q[j] <= lim_q[j-1];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			res_q[i] <= lim_q[LIM_LAT-1] ? rn[i] : v2_q[V2_LAT-1][i];
		end
		lim_out_q <= lim_q[LIM_LAT-1];
	end

	assign out_x       = res_q[0];
	assign out_y       = res_q[1];
	assign out_z       = res_q[2];
	assign was_limited = lim_out_q;

endmodule

/* rtl/core/alds_chk.sv */
// ----------------------------------------------------------------------------
// alds_chk
// Port-level checks of the steering core, bound to the top level.
// ----------------------------------------------------------------------------
module alds_chk import alds_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    start,
	input logic                    busy,
	input logic                    done,
	input logic signed [OUT_W-1:0] out_x,
	input logic signed [OUT_W-1:0] out_y,
	input logic signed [OUT_W-1:0] out_z
);

	a_done_has_word: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, PIPE_LAT))
		else $error("done without an accepted word");

	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (out_x <= ONE && out_x >= -ONE && out_y <= ONE && out_y >= -ONE
			&& out_z <= ONE && out_z >= -ONE))
		else $error("result component beyond one");

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy)
		else $error("word refused");

endmodule

bind angle_limited_direction_steer_core alds_chk u_alds_chk (.*);

/* dv/tb_angle_limited_direction_steer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_angle_limited_direction_steer_core
// Self-checking bench for the turn-rate-limited steering core. A driver pulls
// direction pairs from a queue and a monitor checks each done word against a
// fixed-point prediction of the normalise, arccos, limit and blend datapath.
// ----------------------------------------------------------------------------
module tb_angle_limited_direction_steer_core;
	import alds_pkg::*;

	typedef struct {
		logic signed [COMP_W-1:0] c[3];
		logic signed [COMP_W-1:0] w[3];
	} pair_t;

	typedef struct {
		logic signed [OUT_W-1:0] d[3];
		logic                    lim;
	} steer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [COMP_W-1:0] cur_x = '0, cur_y = '0, cur_z = '0;
	logic signed [COMP_W-1:0] want_x = '0, want_y = '0, want_z = '0;
	logic cfg_we = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic done;
	logic signed [OUT_W-1:0] out_x, out_y, out_z;
	logic was_limited;

	pair_t  pending[$];
	steer_t expected_dirs[$];
	int     errors = 0;
	int     cycles = 0;
	int     gap = 0;
	bit     quiet = 1'b0;
	logic [CFG_W-1:0] turn_limit = CFG_W'(CFG_RESET);

	angle_limited_direction_steer_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cur_x(cur_x), .cur_y(cur_y), .cur_z(cur_z),
		.want_x(want_x), .want_y(want_y), .want_z(want_z),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done),
		.out_x(out_x), .out_y(out_y), .out_z(out_z), .was_limited(was_limited)
	);

	always #5 clk = ~clk;

	function automatic longint isqrt(longint v);
		longint r, b;
		r = 0;
		b = 64'sd1 <<< 62;
		while (b > v) b = b >>> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >>> 1) + b;
			end else begin
				r = r >>> 1;
			end
			b = b >>> 2;
		end
		return r;
	endfunction

	function automatic void unit_vec(input longint c[3], output longint u[3]);
		longint m[3];
		longint s, len, q;
		s = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = c[i] < 0 ? -c[i] : c[i];
			s += m[i] * m[i];
		end
		len = isqrt(s);
		for (int i = 0; i < 3; i++) begin
			if (len == 0) begin
				u[i] = 0;
			end else begin
				q = ((m[i] <<< FRAC_BITS) + (len >>> 1)) / len;
				u[i] = c[i] < 0 ? -q : q;
			end
		end
	endfunction

	function automatic longint angle_of(longint d);
		longint s, x, y, z, dx, dy;
		s = isqrt(longint'(ONE) * ONE - d * d);
		z = 0;
		if (d < 0) begin
			x = s; y = -d; z = ANG_HALF_PI;
		end else begin
			x = d; y = s;
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx; y -= dy; z += atan_q13(CD_STEP_W'(i));
			end else begin
				x -= dx; y += dy; z -= atan_q13(CD_STEP_W'(i));
			end
		end
		return z;
	endfunction

	function automatic steer_t steer(pair_t p, logic [CFG_W-1:0] lim_cfg);
		steer_t r;
		longint a[3], b[3], v1[3], v2[3], bl[3], res[3];
		longint dot, ang, lim, frac;
		for (int i = 0; i < 3; i++) begin
			a[i] = p.c[i];
			b[i] = p.w[i];
		end
		unit_vec(a, v1);
		unit_vec(b, v2);
		dot = 0;
		for (int i = 0; i < 3; i++) dot += v1[i] * v2[i];
		dot = (dot + HALF) >>> FRAC_BITS;
		if (dot > ONE) dot = ONE;
		if (dot < -ONE) dot = -ONE;
		ang = angle_of(dot);
		lim = (longint'(lim_cfg) * ANG_PI + TENTHS_HALF) / 1800;
		r.lim = 1'b0;
		if (ang <= lim) begin
			res = v2;
		end else begin
			frac = (lim <<< FRAC_BITS) / ang;
			for (int i = 0; i < 3; i++)
				bl[i] = v1[i] + (((v2[i] - v1[i]) * frac + HALF) >>> FRAC_BITS);
			unit_vec(bl, res);
			r.lim = 1'b1;
		end
		for (int i = 0; i < 3; i++) r.d[i] = OUT_W'(res[i]);
		return r;
	endfunction

	task automatic report(string what, longint got, longint exp);
		errors++;
		$display("mismatch %s: got %0d, expected %0d", what, got, exp);
	endtask

	// driver
	always @(negedge clk) begin
		if (arst_n && !busy && start) begin
			expected_dirs.push_back(steer(pending.pop_front(), turn_limit));
		end
		if (arst_n && !(start && busy)) begin
			if (gap > 0) begin
				gap <= gap - 1;
				start <= 1'b0;
			end else if (!quiet && pending.size() > 1 && $urandom_range(0, 15) == 0) begin
				gap <= $urandom_range(1, 8) - 1;
				start <= 1'b0;
			end else if (pending.size() > 0) begin
				pair_t p;
				p = pending[0];
				{cur_x, cur_y, cur_z} <= {p.c[0], p.c[1], p.c[2]};
				{want_x, want_y, want_z} <= {p.w[0], p.w[1], p.w[2]};
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && done) begin
			if (expected_dirs.size() == 0) begin
				report("unexpected word", 0, 0);
			end else begin
				steer_t e;
				e = expected_dirs.pop_front();
				if (out_x !== e.d[0]) report("out_x", out_x, e.d[0]);
				if (out_y !== e.d[1]) report("out_y", out_y, e.d[1]);
				if (out_z !== e.d[2]) report("out_z", out_z, e.d[2]);
				if (was_limited !== e.lim) report("was_limited", was_limited, e.lim);
			end
		end
	end

	always @(posedge clk) begin
		if (cycles > 400000) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic logic signed [COMP_W-1:0] rnd_comp();
		case ($urandom_range(0, 5))
			0: return COMP_W'($urandom_range(0, 6) - 3);
			1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			2: return COMP_W'($urandom_range(0, 255) - 128);
			default: return COMP_W'($urandom);
		endcase
	endfunction

	task automatic add_pair(int cx, int cy, int cz, int wx, int wy, int wz);
		pair_t p;
		p.c[0] = COMP_W'(cx); p.c[1] = COMP_W'(cy); p.c[2] = COMP_W'(cz);
		p.w[0] = COMP_W'(wx); p.w[1] = COMP_W'(wy); p.w[2] = COMP_W'(wz);
		pending.push_back(p);
	endtask

	task automatic add_random(int n);
		pair_t p;
		for (int k = 0; k < n; k++) begin
			for (int i = 0; i < 3; i++) begin
				p.c[i] = rnd_comp();
				p.w[i] = rnd_comp();
			end
			// want components near plus or minus the cur ones, sign picked per component
			if ($urandom_range(0, 3) == 0)
				for (int i = 0; i < 3; i++)
					p.w[i] = COMP_W'(($urandom_range(0, 1) ? p.c[i] : -p.c[i])
						+ COMP_W'($urandom_range(0, 8)) - 4);
			pending.push_back(p);
		end
	endtask

	task automatic drain();
		while (pending.size() != 0 || expected_dirs.size() != 0) @(posedge clk);
		repeat (PIPE_LAT + 10) @(posedge clk);
	endtask

	task automatic set_limit(logic [CFG_W-1:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		turn_limit = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [CFG_W-1:0] limits[6];
		limits = '{11'd0, 11'd1800, 11'd2047, 11'd1, 11'd900, 11'd450};
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		// directed, reset limit of 45 degrees
		add_pair(0, 0, 0, 0, 0, 0);
		add_pair(0, 0, 0, 100, 0, 0);
		add_pair(100, 0, 0, 0, 0, 0);
		add_pair(32767, 0, 0, 32767, 0, 0);
		add_pair(-32768, -32768, -32768, 32767, 32767, 32767);
		add_pair(1, 0, 0, -1, 0, 0);
		add_pair(1, 0, 0, 0, 1, 0);
		add_pair(1000, 0, 0, 1000, 900, 0);
		add_pair(-32768, 0, 0, 0, -32768, 0);
		add_pair(3, -4, 12, -3, 4, -12);
		add_pair(0, 0, -1, 0, 0, 32767);
		add_pair(5, 5, 5, 5, 5, 6);
		add_random(200);
		drain();
		foreach (limits[i]) begin
			set_limit(limits[i]);
			add_pair(1, 0, 0, -1, 0, 0);
			add_pair(1, 0, 0, 0, 1, 0);
			add_random(150);
			drain();
		end
		quiet = 1'b1;
		set_limit(CFG_W'($urandom_range(0, 2047)));
		add_random(100);
		drain();
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
